// File: rtl/h2c_pkg.sv
package h2c_pkg;

  localparam int ORDER_BITS = 21;
  localparam int IDX_W      = 2 * ORDER_BITS;
  localparam int LVL_W      = (ORDER_BITS > 2) ? $clog2(ORDER_BITS) : 1;

  localparam logic OP_ENCODE = 1'b0;
  localparam logic OP_DECODE = 1'b1;

  typedef logic [ORDER_BITS-1:0] coord_t;
  typedef logic [IDX_W-1:0]      index_t;
  typedef logic [LVL_W-1:0]      level_t;

  // Working pair of transposed words as it moves down the cell chain.
  typedef struct packed {
    logic   op;
    coord_t w0;
    coord_t w1;
  } h2c_word_t;

  typedef struct packed {
    logic      vld;
    h2c_word_t word;
  } h2c_stage_t;

  typedef struct packed {
    logic   vld;
    index_t index_out;
    coord_t x_out;
    coord_t y_out;
  } h2c_res_t;

endpackage

// File: rtl/h2c_if.sv
interface h2c_in_if import h2c_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   opcode;
  coord_t point_x;
  coord_t point_y;
  index_t curve_index;

  modport source (output valid, output opcode, output point_x, output point_y,
                  output curve_index, input ready);
  modport sink (input valid, input opcode, input point_x, input point_y,
                input curve_index, output ready);
endinterface

interface h2c_out_if import h2c_pkg::*; ();
  logic   valid;
  logic   ready;
  index_t index_out;
  coord_t x_out;
  coord_t y_out;

  modport source (output valid, output index_out, output x_out, output y_out,
                  input ready);
  modport sink (input valid, input index_out, input x_out, input y_out,
                output ready);
endinterface

// File: rtl/h2c_front.sv
module h2c_front import h2c_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  h2c_in_if.sink     in_ch,
  output h2c_stage_t stg_o
);

  logic      vld_r;
  h2c_word_t word_r;
  h2c_word_t word_nxt;

  assign in_ch.ready = en;

  always_comb begin
    coord_t a;
    coord_t b;
    a = '0;
    b = '0;
    word_nxt.op = in_ch.opcode;
    if (in_ch.opcode == OP_ENCODE) begin
      word_nxt.w0 = in_ch.point_x;
      word_nxt.w1 = in_ch.point_y;
    end else begin
      // The odd index bits carry the first word, the even bits the second.
      for (int i = 0; i < ORDER_BITS; i++) begin
        a[i] = in_ch.curve_index[2*i+1];
        b[i] = in_ch.curve_index[2*i];
      end
      word_nxt.w0 = a ^ (b >> 1);
      word_nxt.w1 = b ^ a;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      word_r <= word_nxt;
    end
  end

  assign stg_o = '{vld: vld_r, word: word_r};

endmodule

// File: rtl/h2c_cell.sv
module h2c_cell import h2c_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  level_t     lvl_enc,
  input  level_t     lvl_dec,
  input  h2c_stage_t stg_i,
  output h2c_stage_t stg_o
);

  logic      vld_r;
  h2c_word_t word_r;
  h2c_word_t word_nxt;

  always_comb begin
    level_t lvl;
    coord_t p;
    coord_t a;
    coord_t b;
    coord_t t;
    logic   hx;
    logic   hy;
    lvl = (stg_i.word.op == OP_ENCODE) ? lvl_enc : lvl_dec;
    p   = (coord_t'(1) << lvl) - coord_t'(1);
    a   = stg_i.word.w0;
    b   = stg_i.word.w1;
    // Bit lvl of either word is never touched below, so sample it once.
    hx  = a[lvl];
    hy  = b[lvl];
    t   = (a ^ b) & p;
    if (stg_i.word.op == OP_ENCODE) begin
      if (hx) begin
        a = a ^ p;
        t = (a ^ b) & p;
      end
      if (hy) begin
        a = a ^ p;
      end else begin
        a = a ^ t;
        b = b ^ t;
      end
    end else begin
      if (hy) begin
        a = a ^ p;
      end else begin
        a = a ^ t;
        b = b ^ t;
      end
      if (hx) begin
        a = a ^ p;
      end
    end
    word_nxt = '{op: stg_i.word.op, w0: a, w1: b};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= stg_i.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      word_r <= word_nxt;
    end
  end

  assign stg_o = '{vld: vld_r, word: word_r};

endmodule

// File: rtl/h2c_back.sv
module h2c_back import h2c_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  h2c_stage_t stg_i,
  output h2c_res_t   res_o
);

  logic     vld_r;
  h2c_res_t res_r;
  h2c_res_t res_nxt;

  always_comb begin
    coord_t g;
    coord_t t;
    coord_t a;
    coord_t b;
    index_t idx;
    g   = stg_i.word.w1 ^ stg_i.word.w0;
    t   = '0;
    idx = '0;
    // Each correction bit is the parity of the Gray word above it.
    for (int j = 0; j < ORDER_BITS; j++) begin
      t[j] = ^(g >> (j + 1));
    end
    a = stg_i.word.w0 ^ t;
    b = g ^ t;
    for (int i = 0; i < ORDER_BITS; i++) begin
      idx[2*i+1] = a[i];
      idx[2*i]   = b[i];
    end
    res_nxt.vld = stg_i.vld;
    if (stg_i.word.op == OP_ENCODE) begin
      res_nxt.index_out = idx;
      res_nxt.x_out     = '0;
      res_nxt.y_out     = '0;
    end else begin
      res_nxt.index_out = '0;
      res_nxt.x_out     = stg_i.word.w0;
      res_nxt.y_out     = stg_i.word.w1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= stg_i.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  always_comb begin
    res_o     = res_r;
    res_o.vld = vld_r;
  end

endmodule

// File: rtl/h2c_outbuf.sv
module h2c_outbuf import h2c_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  h2c_res_t res_i,
  output logic     adv,
  h2c_out_if.source out_ch
);

  logic     main_vld_r;
  logic     skid_vld_r;
  h2c_res_t main_r;
  h2c_res_t skid_r;
  logic     push;
  logic     pop;

  // The chain only moves while the skid slot is free, so at most one beat
  // can land here while the main slot is held by the receiver.
  assign adv  = !skid_vld_r;
  assign push = res_i.vld && !skid_vld_r;
  assign pop  = main_vld_r && out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      if (pop) begin
        skid_vld_r <= 1'b0;
      end
    end else if (push) begin
      if (!main_vld_r || pop) begin
        main_vld_r <= 1'b1;
      end else begin
        skid_vld_r <= 1'b1;
      end
    end else if (pop) begin
      main_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld_r) begin
      if (pop) begin
        main_r <= skid_r;
      end
    end else if (push) begin
      if (!main_vld_r || pop) begin
        main_r <= res_i;
      end else begin
        skid_r <= res_i;
      end
    end
  end

  assign out_ch.valid     = main_vld_r;
  assign out_ch.index_out = main_r.index_out;
  assign out_ch.x_out     = main_r.x_out;
  assign out_ch.y_out     = main_r.y_out;

`ifndef SYNTHESIS
  a_skid_needs_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> main_vld_r)
    else $error("skid slot holds a beat while the main slot is empty");

  a_skid_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_vld_r) |-> $past(main_vld_r && !out_ch.ready))
    else $error("skid slot filled without a stalled output");

  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r && out_ch.ready |=> !skid_vld_r && main_vld_r)
    else $error("skid slot did not move to the main slot");
`endif

endmodule

// File: rtl/hilbert_2d_codec_top.sv
// Two-dimensional Hilbert curve codec, fully pipelined.
// Input channel in_ch: a beat carries opcode, point_x, point_y and
// curve_index. Opcode encode maps (point_x, point_y) to a curve index;
// opcode decode maps curve_index back to a point. Result channel out_ch:
// one beat per input beat, in order, with index_out for an encode and
// x_out / y_out for a decode; the unused fields read as zero.
// The datapath is a front register, a chain of ORDER_BITS-1 bit-level cells
// (one curve level each), a back register for the Gray and parity fixup
// and a two-slot output buffer. Throughput is one beat per cycle while the
// buffer's second slot is free, set by the cell chain, which takes a new beat
// every cycle unless the chain holds.
// A stalled receiver first fills the buffer's second slot; the whole chain
// then holds and in_ch.ready drops. in_ch.ready is a register output and
// does not depend on out_ch.ready in the same cycle.
// Reset (rst_n low, synchronous) empties every stage and the buffer by clearing
// their valid flags; the data registers are not reset.
module hilbert_2d_codec_top import h2c_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  h2c_in_if.sink    in_ch,
  h2c_out_if.source out_ch
);

  logic       adv;
  h2c_stage_t stg [ORDER_BITS];
  h2c_res_t   res;

  h2c_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (adv),
    .in_ch (in_ch),
    .stg_o (stg[0])
  );

  // Encode walks the levels from the top down, decode from the bottom up.
  for (genvar s = 0; s < ORDER_BITS - 1; s++) begin : g_cell
    h2c_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (adv),
      .lvl_enc (LVL_W'(ORDER_BITS - 1 - s)),
      .lvl_dec (LVL_W'(s + 1)),
      .stg_i   (stg[s]),
      .stg_o   (stg[s+1])
    );
  end

  h2c_back u_back (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (adv),
    .stg_i (stg[ORDER_BITS-1]),
    .res_o (res)
  );

  h2c_outbuf u_outbuf (
    .clk    (clk),
    .rst_n  (rst_n),
    .res_i  (res),
    .adv    (adv),
    .out_ch (out_ch)
  );

endmodule
